[rtl/lz77d_pkg.sv]
// ---------------------------------------------------------------------------
// lz77d_pkg
// Shared widths, default sizes and payload types of the LZ77 token decoder.
// ---------------------------------------------------------------------------
package lz77d_pkg;

	localparam int DIST_W = 12;
	localparam int LEN_W = 6;
	localparam int LIT_W = 16;
	localparam int TOK_W = 16;

	localparam int WINDOW_DEF = 2048;
	localparam int MAX_LEN_DEF = 63;
	localparam int TOKEN_BITS_DEF = 16;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [LEN_W-1:0]  run_length;
		logic [LIT_W-1:0]  literal_token;
	} triple_t;

	typedef struct packed {
		logic [TOK_W-1:0] token;
		logic             from_copy;
		logic             bad_distance;
		logic             last;
	} result_t;

endpackage

[rtl/lz77d_hist_ram.sv]
// ---------------------------------------------------------------------------
// lz77d_hist_ram
// History ring storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module lz77d_hist_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-during-write to the same entry returns the old data
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/lz77_token_decoder_core.sv]
// ---------------------------------------------------------------------------
// lz77_token_decoder_core
// LZ77 triple decoder: expands (distance, run_length, literal) into a token
// stream, keeping every emitted token in a history ring.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+----------------------
//  triple   | in  | triple_valid / triple_stall | triple_data (triple_t)
//  result   | out | result_valid / result_stall | result_data (result_t)
//
// One triple at a time. Literal only: accept, then literal. Copy run of L
// tokens: accept, read setup, L copies, literal, one token per cycle through
// the history RAM read port while the output does not stall. Output stalls hold the copy and literal states.
// triple_stall stays high from accept until the literal is loaded.
// Reset clears the ring pointer and fill count; RAM contents are left as is.
// ---------------------------------------------------------------------------
module lz77_token_decoder_core
	import lz77d_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    triple_valid,
	output logic    triple_stall,
	input  triple_t triple_data,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	localparam int AW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);
	localparam int CW = (FW > DIST_W) ? FW : DIST_W;

	typedef enum logic [1:0] {
		IDLE,
		START,
		COPY,
		LIT
	} state_t;

	state_t                state_q;
	logic [DIST_W-1:0]     dist_q;
	logic [LEN_W-1:0]      cnt_q;
	logic [TOKEN_BITS-1:0] lit_q;
	logic                  bad_q;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [FW-1:0]         filled_q;
	logic [TOKEN_BITS-1:0] last_tok_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic                  accept;
	logic                  slot_free;
	logic                  push;
	logic [LEN_W-1:0]      len_sat;
	logic [63:0]           lit_wide;
	logic [TOKEN_BITS-1:0] lit_in;
	logic [CW:0]           wp_ext;
	logic [CW:0]           dist_ext;
	logic [CW:0]           start_sum;
	logic [AW-1:0]         start_addr;
	logic                  bad_now;
	logic [AW-1:0]         wp_inc;
	logic [AW-1:0]         rd_inc;
	logic [AW-1:0]         raddr;
	logic [TOKEN_BITS-1:0] rdata;
	logic [TOKEN_BITS-1:0] copy_tok;
	logic [TOKEN_BITS-1:0] wdata;
	logic [63:0]           out_wide;

	assign triple_stall = (state_q != IDLE);
	assign accept = triple_valid && !triple_stall;
	assign slot_free = !res_valid_q || !result_stall;
	assign push = slot_free && (state_q == COPY || state_q == LIT);

	assign len_sat = (triple_data.run_length > LEN_W'(MAX_LEN)) ?
		LEN_W'(MAX_LEN) : triple_data.run_length;
	assign lit_wide = 64'(triple_data.literal_token);
	assign lit_in = lit_wide[TOKEN_BITS-1:0];

	// start of the copy: write pointer minus distance, modulo the ring size
	assign wp_ext = (CW+1)'(wp_q);
	assign dist_ext = (CW+1)'(dist_q);
	assign start_sum = (wp_ext >= dist_ext) ? (wp_ext - dist_ext) :
		(wp_ext + (CW+1)'(WINDOW) - dist_ext);
	assign start_addr = start_sum[AW-1:0];
	assign bad_now = CW'(dist_q) > CW'(filled_q);

	assign wp_inc = (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign rd_inc = (rd_ptr_q == AW'(WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;

	always_comb begin
		raddr = rd_ptr_q;
		if (state_q == START) begin
			raddr = start_addr;
		end else if (state_q == COPY && slot_free) begin
			raddr = rd_inc;
		end
	end

	// distance one reads the slot written in the same cycle: take the last token
	assign copy_tok = bad_q ? '0 : ((dist_q == DIST_W'(1)) ? last_tok_q : rdata);
	assign wdata = (state_q == LIT) ? lit_q : copy_tok;
	assign out_wide = 64'(wdata);

	lz77d_hist_ram #(
		.DEPTH(WINDOW),
		.WIDTH(TOKEN_BITS)
	) u_hist (
		.clk  (clk),
		.we   (push),
		.waddr(wp_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			wp_q <= '0;
			filled_q <= '0;
			res_valid_q <= 1'b0;
			cnt_q <= '0;
			bad_q <= 1'b0;
			dist_q <= '0;
			lit_q <= '0;
			rd_ptr_q <= '0;
			last_tok_q <= '0;
			res_q <= '0;
		end else begin
			if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (push) begin
				wp_q <= wp_inc;
				if (filled_q != FW'(WINDOW)) begin
					filled_q <= filled_q + 1'b1;
				end
				last_tok_q <= wdata;
				res_valid_q <= 1'b1;
				res_q.token <= out_wide[TOK_W-1:0];
				res_q.from_copy <= (state_q == COPY);
				res_q.bad_distance <= bad_q;
				res_q.last <= (state_q == LIT);
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						dist_q <= triple_data.distance;
						cnt_q <= len_sat;
						lit_q <= lit_in;
						bad_q <= 1'b0;
						if (triple_data.distance == '0 || triple_data.run_length == '0) begin
							state_q <= LIT;
						end else begin
							state_q <= START;
						end
					end
				end
				START: begin
					bad_q <= bad_now;
					rd_ptr_q <= start_addr;
					state_q <= COPY;
				end
				COPY: begin
					if (slot_free) begin
						rd_ptr_q <= rd_inc;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == LEN_W'(1)) begin
							state_q <= LIT;
						end
					end
				end
				LIT: begin
					if (slot_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_data = res_q;

endmodule
